// File: src/escaped_frame_receiver_crc16_assert.svh
// assertion macros shared by the frame receiver modules
`ifndef ESCAPED_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_CRC16_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, disabled while in reset
`define EFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("frame receiver assertion failed");

// next-cycle implication, disabled while in reset
`define EFR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("frame receiver assertion failed");

`else

`define EFR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define EFR_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: src/efr_pkg.sv
// shared types, constants and the crc step of the frame receiver
package efr_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] len_t;
  typedef logic [2:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_HEADER_FIRST  = 3'd0;
  localparam cfg_idx_t CFG_HEADER_SECOND = 3'd1;
  localparam cfg_idx_t CFG_TAIL_FIRST    = 3'd2;
  localparam cfg_idx_t CFG_TAIL_SECOND   = 3'd3;
  localparam cfg_idx_t CFG_LENGTH_LIMIT  = 3'd4;

  // configuration reset values
  localparam byte_t RST_HEADER_FIRST  = 8'hAA;
  localparam byte_t RST_HEADER_SECOND = 8'h55;
  localparam byte_t RST_TAIL_FIRST    = 8'h0D;
  localparam byte_t RST_TAIL_SECOND   = 8'h0A;
  localparam len_t  RST_LENGTH_LIMIT  = 4'd12;

  // payload escape codes and their decoded values
  localparam byte_t ESC_BYTE    = 8'hCC;
  localparam byte_t ESC_CODE_AA = 8'h01;
  localparam byte_t ESC_CODE_55 = 8'h02;
  localparam byte_t ESC_CODE_0D = 8'h03;
  localparam byte_t ESC_CODE_0A = 8'h04;
  localparam byte_t DEC_AA      = 8'hAA;
  localparam byte_t DEC_55      = 8'h55;
  localparam byte_t DEC_0D      = 8'h0D;
  localparam byte_t DEC_0A      = 8'h0A;

  // crc-16/modbus
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // two payload banks, one per pending frame
  localparam int NUM_BANKS = 2;

  typedef struct packed {
    byte_t header_first;
    byte_t header_second;
    byte_t tail_first;
    byte_t tail_second;
    len_t  length_limit;
  } cfg_t;

  typedef struct packed {
    byte_t address;
    byte_t command;
    len_t  length;
    logic  bank;
  } desc_t;

  // one byte through the reflected crc, bit at a time
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input byte_t b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// File: src/efr_in_if.sv
// received byte channel
interface efr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: src/efr_out_if.sv
// decoded frame result channel
interface efr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_address;
  logic [7:0] frame_command;
  logic [3:0] frame_length;
  logic [7:0] payload_byte;
  logic       payload_present;
  logic [3:0] byte_position;
  logic       last_of_frame;

  modport source (output valid, output frame_address, output frame_command,
                  output frame_length, output payload_byte, output payload_present,
                  output byte_position, output last_of_frame, input ready);
  modport sink (input valid, input frame_address, input frame_command,
                input frame_length, input payload_byte, input payload_present,
                input byte_position, input last_of_frame, output ready);
endinterface

// File: src/efr_ram.sv
// generic single-write, single-read ram with registered read data
module efr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// File: src/efr_front.sv
// frame parser: header hunt, field capture, unescaping, crc and tail check
`include "escaped_frame_receiver_crc16_assert.svh"
module efr_front #(
  parameter int MAX_PAYLOAD = 12
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  efr_pkg::cfg_t                                  cfg_i,
  input  logic                                           in_valid_i,
  input  efr_pkg::byte_t                                 in_byte_i,
  output logic                                           in_ready_o,
  input  logic                                           space_i,
  output logic                                           push_o,
  output efr_pkg::desc_t                                 desc_o,
  output logic                                           ram_we_o,
  output logic [$clog2(efr_pkg::NUM_BANKS*MAX_PAYLOAD)-1:0] ram_waddr_o,
  output efr_pkg::byte_t                                 ram_wdata_o
);
  import efr_pkg::*;

  localparam int AW = $clog2(NUM_BANKS * MAX_PAYLOAD);
  localparam byte_t MAX_LEN = 8'(MAX_PAYLOAD);

  typedef enum logic [10:0] {
    S_HUNT    = 11'b000_0000_0001,
    S_HDR2    = 11'b000_0000_0010,
    S_ADDR    = 11'b000_0000_0100,
    S_CMD     = 11'b000_0000_1000,
    S_LEN     = 11'b000_0001_0000,
    S_DATA    = 11'b000_0010_0000,
    S_ESC     = 11'b000_0100_0000,
    S_CRC_HI  = 11'b000_1000_0000,
    S_CRC_LO  = 11'b001_0000_0000,
    S_TAIL1   = 11'b010_0000_0000,
    S_TAIL2   = 11'b100_0000_0000
  } state_t;

  state_t      state_r, state_nxt;
  byte_t       addr_r, addr_nxt;
  byte_t       cmd_r, cmd_nxt;
  len_t        len_r, len_nxt;
  len_t        fill_r, fill_nxt;
  logic [15:0] rxcrc_r, rxcrc_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        bank_r, bank_nxt;

  logic        accept;
  logic        store_en;
  byte_t       store_val;
  byte_t       eff_limit;
  len_t        fill_inc;
  byte_t       b;

  assign b          = in_byte_i;
  assign accept     = in_valid_i && space_i;
  assign in_ready_o = space_i;
  assign fill_inc   = fill_r + 4'd1;

  // length limit clipped to the store size
  assign eff_limit = ({4'b0, cfg_i.length_limit} > MAX_LEN) ? MAX_LEN
                                                          : {4'b0, cfg_i.length_limit};

  // parser next state
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    fill_nxt  = fill_r;
    rxcrc_nxt = rxcrc_r;
    crc_nxt   = crc_r;
    bank_nxt  = bank_r;
    store_en  = 1'b0;
    store_val = b;
    push_o    = 1'b0;
    if (accept) begin
      unique case (state_r)
        S_HDR2: begin
          state_nxt = (b == cfg_i.header_second) ? S_ADDR : S_HUNT;
        end
        S_ADDR: begin
          addr_nxt  = b;
          crc_nxt   = crc16_byte(CRC_INIT, b);
          state_nxt = S_CMD;
        end
        S_CMD: begin
          cmd_nxt   = b;
          crc_nxt   = crc16_byte(crc_r, b);
          state_nxt = S_LEN;
        end
        S_LEN: begin
          if (b <= eff_limit) begin
            len_nxt   = b[3:0];
            fill_nxt  = '0;
            crc_nxt   = crc16_byte(crc_r, b);
            state_nxt = (b != 8'h00) ? S_DATA : S_CRC_HI;
          end else begin
            state_nxt = S_HUNT;
          end
        end
        S_DATA: begin
          if (b == ESC_BYTE) begin
            state_nxt = S_ESC;
          end else begin
            store_en = 1'b1;
          end
        end
        S_ESC: begin
          unique case (b)
            ESC_CODE_AA: begin
              store_en  = 1'b1;
              store_val = DEC_AA;
            end
            ESC_CODE_55: begin
              store_en  = 1'b1;
              store_val = DEC_55;
            end
            ESC_CODE_0D: begin
              store_en  = 1'b1;
              store_val = DEC_0D;
            end
            ESC_CODE_0A: begin
              store_en  = 1'b1;
              store_val = DEC_0A;
            end
            ESC_BYTE: begin
              store_en  = 1'b1;
              store_val = ESC_BYTE;
            end
            default: begin
              state_nxt = S_HUNT;
            end
          endcase
        end
        S_CRC_HI: begin
          rxcrc_nxt = {b, 8'h00};
          state_nxt = S_CRC_LO;
        end
        S_CRC_LO: begin
          rxcrc_nxt = {rxcrc_r[15:8], b};
          state_nxt = S_TAIL1;
        end
        S_TAIL1: begin
          state_nxt = (b == cfg_i.tail_first) ? S_TAIL2 : S_HUNT;
        end
        S_TAIL2: begin
          state_nxt = S_HUNT;
          if ((b == cfg_i.tail_second) && (crc_r == rxcrc_r)) begin
            push_o   = 1'b1;
            bank_nxt = ~bank_r;
          end
        end
        default: begin
          state_nxt = (b == cfg_i.header_first) ? S_HDR2 : S_HUNT;
        end
      endcase

      // one decoded payload byte
      if (store_en) begin
        fill_nxt  = fill_inc;
        crc_nxt   = crc16_byte(crc_r, store_val);
        state_nxt = (fill_inc >= len_r) ? S_CRC_HI : S_DATA;
      end
    end
  end

  // payload write into the current bank
  assign ram_we_o    = store_en && ({4'b0, fill_r} < MAX_LEN);
  assign ram_wdata_o = store_val;
  assign ram_waddr_o = (bank_r ? AW'(MAX_PAYLOAD) : AW'(0)) + AW'(fill_r);

  assign desc_o = '{address: addr_r, command: cmd_r, length: len_r, bank: bank_r};

  // parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
      addr_r  <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
      fill_r  <= '0;
      rxcrc_r <= '0;
      crc_r   <= CRC_INIT;
      bank_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      fill_r  <= fill_nxt;
      rxcrc_r <= rxcrc_nxt;
      crc_r   <= crc_nxt;
      bank_r  <= bank_nxt;
    end
  end

  `EFR_ASSERT_IMP(a_push_has_room, clk, rst_n, push_o, space_i)
  `EFR_ASSERT_IMP(a_write_below_length, clk, rst_n, ram_we_o, fill_r < len_r)
  `EFR_ASSERT_IMP(a_payload_len_nonzero, clk, rst_n, (state_r == S_DATA) || (state_r == S_ESC), len_r != 4'd0)
endmodule

// File: src/efr_queue.sv
// two-entry queue of good-frame descriptors between parser and emitter
module efr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  efr_pkg::desc_t desc_i,
  input  logic           pop_i,
  output efr_pkg::desc_t desc_o,
  output logic [1:0]     count_o
);
  import efr_pkg::*;

  desc_t      entry_r [NUM_BANKS];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push_i ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_i ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_i) begin
      entry_r[wr_ptr_r] <= desc_i;
    end
  end

  assign desc_o  = entry_r[rd_ptr_r];
  assign count_o = count_r;
endmodule

// File: src/efr_back.sv
// result emitter: walks a good frame's payload and presents one result at a time
`include "escaped_frame_receiver_crc16_assert.svh"
module efr_back #(
  parameter int MAX_PAYLOAD = 12
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              avail_i,
  input  efr_pkg::desc_t                                    desc_i,
  output logic                                              pop_o,
  output logic                                              busy_o,
  output logic                                              ram_re_o,
  output logic [$clog2(efr_pkg::NUM_BANKS*MAX_PAYLOAD)-1:0] ram_raddr_o,
  input  efr_pkg::byte_t                                    ram_rdata_i,
  output logic                                              out_valid_o,
  input  logic                                              out_ready_i,
  output efr_pkg::byte_t                                    frame_address_o,
  output efr_pkg::byte_t                                    frame_command_o,
  output efr_pkg::len_t                                     frame_length_o,
  output efr_pkg::byte_t                                    payload_byte_o,
  output logic                                              payload_present_o,
  output efr_pkg::len_t                                     byte_position_o,
  output logic                                              last_of_frame_o
);
  import efr_pkg::*;

  localparam int AW = $clog2(NUM_BANKS * MAX_PAYLOAD);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_SHOW = 3'b100
  } bstate_t;

  bstate_t state_r, state_nxt;
  desc_t   desc_r, desc_nxt;
  len_t    pos_r, pos_nxt;
  len_t    pos_inc;
  logic    present;
  logic    last;

  assign pos_inc = pos_r + 4'd1;
  assign present = (desc_r.length != 4'd0);
  assign last    = !present || (pos_inc == desc_r.length);

  // emitter sequencing
  always_comb begin
    state_nxt = state_r;
    desc_nxt  = desc_r;
    pos_nxt   = pos_r;
    pop_o     = 1'b0;
    ram_re_o  = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (avail_i) begin
          pop_o     = 1'b1;
          desc_nxt  = desc_i;
          pos_nxt   = '0;
          state_nxt = B_READ;
        end
      end
      B_READ: begin
        ram_re_o  = 1'b1;
        state_nxt = B_SHOW;
      end
      B_SHOW: begin
        if (out_ready_i) begin
          if (last) begin
            state_nxt = B_IDLE;
          end else begin
            pos_nxt   = pos_inc;
            state_nxt = B_READ;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // descriptor of the frame being emitted
  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
  end

  assign ram_raddr_o = (desc_r.bank ? AW'(MAX_PAYLOAD) : AW'(0)) + AW'(pos_r);
  assign busy_o      = (state_r != B_IDLE);

  // result fields
  assign out_valid_o       = (state_r == B_SHOW);
  assign frame_address_o   = desc_r.address;
  assign frame_command_o   = desc_r.command;
  assign frame_length_o    = desc_r.length;
  assign payload_byte_o    = present ? ram_rdata_i : 8'h00;
  assign payload_present_o = present;
  assign byte_position_o   = pos_r;
  assign last_of_frame_o   = last;

  `EFR_ASSERT_IMP(a_pop_needs_entry, clk, rst_n, pop_o, avail_i)
  `EFR_ASSERT_IMP(a_pos_in_payload, clk, rst_n, (state_r == B_SHOW) && present, pos_r < desc_r.length)
  `EFR_ASSERT_NXT(a_read_then_show, clk, rst_n, ram_re_o, out_valid_o && !pop_o)
endmodule

// File: src/escaped_frame_receiver_crc16.sv
// Escaped frame receiver with CRC-16/MODBUS check.
// in_ch carries one received byte per transaction; out_ch carries one result per
// payload byte of a good frame, or a single result for an empty payload, with
// last_of_frame set on the final one. cfg_we/cfg_index/cfg_wdata write the header,
// tail and length-limit registers; write only while the block is idle.
// Input: one byte per cycle. The parser updates the crc over a whole byte each
// cycle, so in_ch.ready stays high except while two good frames are pending (one
// being emitted, one waiting in the two-entry descriptor queue), since each
// pending frame holds one of the two payload banks.
// Output: the first result of a good frame follows the second tail byte through the
// descriptor queue, the emitter's descriptor load and a payload ram read. Each result
// is a payload ram read, then the presented result, held while out_ch.ready is low.
// Reset: synchronous on rst_n low; control and config registers take their defaults,
// the parser hunts for the header and the queue is empty. No clearing pass.
// A stalled sink holds the current result stable; bytes keep being parsed until
// both banks are taken, then in_ch.ready drops.
module escaped_frame_receiver_crc16 #(
  parameter int MAX_PAYLOAD = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  efr_in_if.sink            in_ch,
  efr_out_if.source         out_ch,
  input  logic              cfg_we,
  input  efr_pkg::cfg_idx_t cfg_index,
  input  efr_pkg::byte_t    cfg_wdata
);
  import efr_pkg::*;

  localparam int RAM_DEPTH = NUM_BANKS * MAX_PAYLOAD;
  localparam int AW = $clog2(RAM_DEPTH);

  cfg_t          cfg_r, cfg_nxt;
  logic          space;
  logic          push;
  logic          pop;
  logic          busy;
  desc_t         push_desc;
  desc_t         head_desc;
  logic [1:0]    q_count;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  byte_t         ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  byte_t         ram_rdata;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER_FIRST:  cfg_nxt.header_first  = cfg_wdata;
        CFG_HEADER_SECOND: cfg_nxt.header_second = cfg_wdata;
        CFG_TAIL_FIRST:    cfg_nxt.tail_first    = cfg_wdata;
        CFG_TAIL_SECOND:   cfg_nxt.tail_second   = cfg_wdata;
        CFG_LENGTH_LIMIT:  cfg_nxt.length_limit  = cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{header_first:  RST_HEADER_FIRST,
                 header_second: RST_HEADER_SECOND,
                 tail_first:    RST_TAIL_FIRST,
                 tail_second:   RST_TAIL_SECOND,
                 length_limit:  RST_LENGTH_LIMIT};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // a payload bank is free while fewer than two frames are pending
  assign space = ({1'b0, q_count} + {2'b00, busy}) < 3'(NUM_BANKS);

  efr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .in_valid_i  (in_ch.valid),
    .in_byte_i   (in_ch.rx_byte),
    .in_ready_o  (in_ch.ready),
    .space_i     (space),
    .push_o      (push),
    .desc_o      (push_desc),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  efr_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  efr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .desc_i  (push_desc),
    .pop_i   (pop),
    .desc_o  (head_desc),
    .count_o (q_count)
  );

  efr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .avail_i           (q_count != 2'd0),
    .desc_i            (head_desc),
    .pop_o             (pop),
    .busy_o            (busy),
    .ram_re_o          (ram_re),
    .ram_raddr_o       (ram_raddr),
    .ram_rdata_i       (ram_rdata),
    .out_valid_o       (out_ch.valid),
    .out_ready_i       (out_ch.ready),
    .frame_address_o   (out_ch.frame_address),
    .frame_command_o   (out_ch.frame_command),
    .frame_length_o    (out_ch.frame_length),
    .payload_byte_o    (out_ch.payload_byte),
    .payload_present_o (out_ch.payload_present),
    .byte_position_o   (out_ch.byte_position),
    .last_of_frame_o   (out_ch.last_of_frame)
  );
endmodule

// File: bench/tb_escaped_frame_receiver_crc16.sv
// testbench of the escaped frame receiver: frame driver, byte-level predictor and result checks
module tb_escaped_frame_receiver_crc16;
  import efr_pkg::*;

  localparam int PAYLOAD_MAX = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BYTES_PER_PHASE = 16;

  typedef enum logic [3:0] {
    PH_HUNT, PH_HDR2, PH_ADDR, PH_CMD, PH_LEN, PH_DATA, PH_ESC,
    PH_CRC_HI, PH_CRC_LO, PH_TAIL1, PH_TAIL2
  } rx_phase_e;

  typedef enum int {
    FAULT_NONE, FAULT_HEADER, FAULT_LENGTH, FAULT_ESCAPE, FAULT_CRC, FAULT_TAIL1, FAULT_TAIL2
  } frame_fault_e;

  typedef enum int { STUFF_RANDOM, STUFF_ALL, STUFF_NONE } stuff_mode_e;

  typedef byte_t payload_t [PAYLOAD_MAX];

  typedef struct packed {
    byte_t      address;
    byte_t      command;
    logic [3:0] length;
    byte_t      data;
    logic       present;
    logic [3:0] position;
    logic       last;
  } frame_result_t;

  // predicts decoded results byte by byte and checks the result stream in order
  class frame_scoreboard;
    byte_t         header_first, header_second, tail_first, tail_second;
    logic [3:0]    length_limit;
    rx_phase_e     phase;
    byte_t         held_address, held_command;
    logic [3:0]    held_length, fill_index;
    byte_t         payload_store [PAYLOAD_MAX];
    logic [15:0]   received_crc, running_crc;
    frame_result_t expected_q[$];
    int unsigned   error_count;

    function new();
      header_first  = RST_HEADER_FIRST;
      header_second = RST_HEADER_SECOND;
      tail_first    = RST_TAIL_FIRST;
      tail_second   = RST_TAIL_SECOND;
      length_limit  = RST_LENGTH_LIMIT;
      phase         = PH_HUNT;
      held_address  = '0;
      held_command  = '0;
      held_length   = '0;
      fill_index    = '0;
      received_crc  = '0;
      running_crc   = CRC_INIT;
      error_count   = 0;
    endfunction

    // reflected crc fed one data bit at a time, lsb first
    static function logic [15:0] crc_next(logic [15:0] c, byte_t b);
      logic [15:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
        if (r[0] ^ b[i]) r = (r >> 1) ^ CRC_POLY;
        else r = r >> 1;
      end
      return r;
    endfunction

    function int effective_limit();
      return (length_limit > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(length_limit);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void set_register(cfg_idx_t idx, byte_t value);
      case (idx)
        CFG_HEADER_FIRST:  header_first = value;
        CFG_HEADER_SECOND: header_second = value;
        CFG_TAIL_FIRST:    tail_first = value;
        CFG_TAIL_SECOND:   tail_second = value;
        CFG_LENGTH_LIMIT:  length_limit = value[3:0];
        default: ;
      endcase
    endfunction

    function void store_byte(byte_t b);
      if (fill_index < PAYLOAD_MAX) payload_store[fill_index] = b;
      fill_index  = fill_index + 4'd1;
      running_crc = crc_next(running_crc, b);
      phase       = (fill_index >= held_length) ? PH_CRC_HI : PH_DATA;
    endfunction

    // one accepted input transaction
    function void note_byte(byte_t b);
      frame_result_t r;
      case (phase)
        PH_HDR2: phase = (b == header_second) ? PH_ADDR : PH_HUNT;
        PH_ADDR: begin
          held_address = b;
          running_crc  = crc_next(CRC_INIT, b);
          phase        = PH_CMD;
        end
        PH_CMD: begin
          held_command = b;
          running_crc  = crc_next(running_crc, b);
          phase        = PH_LEN;
        end
        PH_LEN: begin
          if (b <= effective_limit()) begin
            held_length = b[3:0];
            fill_index  = '0;
            running_crc = crc_next(running_crc, b);
            phase       = (b != 0) ? PH_DATA : PH_CRC_HI;
          end else begin
            phase = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (b == ESC_BYTE) phase = PH_ESC;
          else store_byte(b);
        end
        PH_ESC: begin
          case (b)
            ESC_CODE_AA: store_byte(DEC_AA);
            ESC_CODE_55: store_byte(DEC_55);
            ESC_CODE_0D: store_byte(DEC_0D);
            ESC_CODE_0A: store_byte(DEC_0A);
            ESC_BYTE:    store_byte(ESC_BYTE);
            default:     phase = PH_HUNT;
          endcase
        end
        PH_CRC_HI: begin
          received_crc = {b, 8'h00};
          phase        = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          received_crc[7:0] = b;
          phase             = PH_TAIL1;
        end
        PH_TAIL1: phase = (b == tail_first) ? PH_TAIL2 : PH_HUNT;
        PH_TAIL2: begin
          phase = PH_HUNT;
          // good frame: one result per payload byte, or one for an empty payload
          if (b == tail_second && running_crc == received_crc) begin
            r.address = held_address;
            r.command = held_command;
            r.length  = held_length;
            if (held_length == 0) begin
              r.data     = '0;
              r.present  = 1'b0;
              r.position = '0;
              r.last     = 1'b1;
              expected_q.push_back(r);
            end else begin
              for (int k = 0; k < held_length; k++) begin
                r.data     = payload_store[k];
                r.present  = 1'b1;
                r.position = k[3:0];
                r.last     = (k == held_length - 1);
                expected_q.push_back(r);
              end
            end
          end
        end
        default: phase = (b == header_first) ? PH_HDR2 : PH_HUNT;
      endcase
    endfunction

    function string describe(frame_result_t r);
      return $sformatf("adr=%h cmd=%h len=%0d data=%h present=%b pos=%0d last=%b",
                       r.address, r.command, r.length, r.data, r.present, r.position, r.last);
    endfunction

    // one accepted result transaction against the oldest prediction
    function void check_result(frame_result_t got);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: expected none, got %s", $time, describe(got));
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          $display("%0t result mismatch: expected %s, got %s", $time, describe(want),
                   describe(got));
          error_count++;
        end
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  byte_t    cfg_wdata;

  efr_in_if  in_ch ();
  efr_out_if out_ch ();

  escaped_frame_receiver_crc16 #(.MAX_PAYLOAD(PAYLOAD_MAX)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  frame_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int sent_count;

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // run limit
  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  // result sink with random stalls
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor of both channels
  always @(posedge clk) begin : monitor
    frame_result_t seen;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        seen.address  = out_ch.frame_address;
        seen.command  = out_ch.frame_command;
        seen.length   = out_ch.frame_length;
        seen.data     = out_ch.payload_byte;
        seen.present  = out_ch.payload_present;
        seen.position = out_ch.byte_position;
        seen.last     = out_ch.last_of_frame;
        sb.check_result(seen);
      end
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_byte(byte_t b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  // stop sending until every predicted result has arrived and the block settles
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, byte_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic apply_setting(byte_t hf, byte_t hs, byte_t tf, byte_t ts, byte_t lim);
    write_register(CFG_HEADER_FIRST, hf);
    write_register(CFG_HEADER_SECOND, hs);
    write_register(CFG_TAIL_FIRST, tf);
    write_register(CFG_TAIL_SECOND, ts);
    write_register(CFG_LENGTH_LIMIT, lim);
  endtask

  // bytes that walk any partial frame back to hunting
  task automatic send_flush();
    byte_t filler;
    filler = (sb.header_first == 8'h00) ? 8'h11 : 8'h00;
    repeat (20) send_byte(filler);
  endtask

  // payload biased toward the bytes that have escape codes
  function automatic payload_t random_payload();
    payload_t pl;
    for (int k = 0; k < PAYLOAD_MAX; k++) begin
      if ($urandom_range(0, 99) < 30) begin
        case ($urandom_range(0, 4))
          0: pl[k] = DEC_AA;
          1: pl[k] = DEC_55;
          2: pl[k] = DEC_0D;
          3: pl[k] = DEC_0A;
          default: pl[k] = ESC_BYTE;
        endcase
      end else begin
        pl[k] = byte_t'($urandom);
      end
    end
    return pl;
  endfunction

  // encodes one frame under the current registers, optionally broken
  task automatic send_frame(byte_t addr, byte_t cmd, byte_t len_byte, payload_t pl,
                            frame_fault_e fault, stuff_mode_e mode);
    logic [15:0] crc;
    int          bad_at;
    byte_t       code;
    logic        stuff;
    send_byte(sb.header_first);
    if (fault == FAULT_HEADER) begin
      code = byte_t'($urandom);
      if (code == sb.header_second) code = ~code;
      send_byte(code);
      return;
    end
    send_byte(sb.header_second);
    send_byte(addr);
    send_byte(cmd);
    send_byte(len_byte);
    if (fault == FAULT_LENGTH) return;
    crc = frame_scoreboard::crc_next(CRC_INIT, addr);
    crc = frame_scoreboard::crc_next(crc, cmd);
    crc = frame_scoreboard::crc_next(crc, len_byte);
    bad_at = (fault == FAULT_ESCAPE) ? $urandom_range(0, len_byte - 1) : -1;
    for (int k = 0; k < len_byte; k++) begin
      // illegal escape ends the frame here
      if (k == bad_at) begin
        do code = byte_t'($urandom);
        while (code inside {ESC_CODE_AA, ESC_CODE_55, ESC_CODE_0D, ESC_CODE_0A, ESC_BYTE});
        send_byte(ESC_BYTE);
        send_byte(code);
        return;
      end
      stuff = (pl[k] == ESC_BYTE) ||
              ((pl[k] inside {DEC_AA, DEC_55, DEC_0D, DEC_0A}) &&
               (mode == STUFF_ALL || (mode == STUFF_RANDOM && $urandom_range(0, 1) == 1)));
      if (stuff) begin
        case (pl[k])
          DEC_AA:  code = ESC_CODE_AA;
          DEC_55:  code = ESC_CODE_55;
          DEC_0D:  code = ESC_CODE_0D;
          DEC_0A:  code = ESC_CODE_0A;
          default: code = ESC_BYTE;
        endcase
        send_byte(ESC_BYTE);
        send_byte(code);
      end else begin
        send_byte(pl[k]);
      end
      crc = frame_scoreboard::crc_next(crc, pl[k]);
    end
    if (fault == FAULT_CRC) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
    if (fault == FAULT_TAIL1) begin
      send_byte(sb.tail_first ^ byte_t'($urandom_range(1, 255)));
      return;
    end
    send_byte(sb.tail_first);
    send_byte((fault == FAULT_TAIL2) ? (sb.tail_second ^ byte_t'($urandom_range(1, 255)))
                                     : sb.tail_second);
  endtask

  // stimulus
  initial begin
    payload_t     pl;
    frame_fault_e fault;
    int           len;
    int           pick;
    int           phase_start;
    bit           paused;

    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = '0;
    out_ch.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_HEADER_FIRST;
    cfg_wdata      = '0;
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    sent_count     = 0;
    sb             = new();
    rst_n          = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty payload with extreme address and command
    pl = random_payload();
    send_frame(8'h00, 8'hFF, 8'd0, pl, FAULT_NONE, STUFF_RANDOM);
    // full payload: every escape code and the byte extremes, stuffed and raw
    pl = '{DEC_AA, DEC_55, DEC_0D, DEC_0A, ESC_BYTE, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F,
           ESC_BYTE, 8'hFE};
    send_frame(8'hFF, 8'h00, 8'd12, pl, FAULT_NONE, STUFF_ALL);
    send_frame(8'h5A, 8'hA5, 8'd12, pl, FAULT_NONE, STUFF_NONE);
    // escape byte outside the payload is taken raw
    send_frame(ESC_BYTE, ESC_BYTE, 8'd3, pl, FAULT_NONE, STUFF_RANDOM);
    // dropped frames, then a good one
    pl = random_payload();
    send_frame(8'h12, 8'h34, 8'd4, pl, FAULT_CRC, STUFF_RANDOM);
    send_frame(8'h12, 8'h34, 8'd4, pl, FAULT_TAIL1, STUFF_RANDOM);
    send_frame(8'h12, 8'h34, 8'd4, pl, FAULT_TAIL2, STUFF_RANDOM);
    send_frame(8'h12, 8'h34, 8'd4, pl, FAULT_ESCAPE, STUFF_RANDOM);
    send_frame(8'h12, 8'h34, 8'd4, pl, FAULT_HEADER, STUFF_RANDOM);
    send_frame(8'h12, 8'h34, 8'd13, pl, FAULT_LENGTH, STUFF_RANDOM);
    send_frame(8'h12, 8'h34, 8'd255, pl, FAULT_LENGTH, STUFF_RANDOM);
    send_frame(8'h21, 8'h43, 8'd5, pl, FAULT_NONE, STUFF_RANDOM);
    // header mismatch: the wrong byte is not taken as a new first header byte
    send_byte(sb.header_first);
    send_frame(8'h66, 8'h77, 8'd2, pl, FAULT_NONE, STUFF_RANDOM);
    send_flush();
    send_frame(8'h67, 8'h78, 8'd2, pl, FAULT_NONE, STUFF_RANDOM);

    // zero length limit: only empty payloads pass
    wait_for_results();
    write_register(CFG_LENGTH_LIMIT, 8'd0);
    send_frame(8'h01, 8'h02, 8'd0, pl, FAULT_NONE, STUFF_RANDOM);
    send_frame(8'h01, 8'h02, 8'd1, pl, FAULT_LENGTH, STUFF_RANDOM);
    send_frame(8'h03, 8'h04, 8'd0, pl, FAULT_NONE, STUFF_RANDOM);

    // limit above the payload size acts as the payload size
    wait_for_results();
    write_register(CFG_LENGTH_LIMIT, 8'd15);
    send_frame(8'h05, 8'h06, 8'd13, pl, FAULT_LENGTH, STUFF_RANDOM);
    send_frame(8'h07, 8'h08, 8'd12, pl, FAULT_NONE, STUFF_RANDOM);

    // writes to indexes past the last register change nothing
    wait_for_results();
    for (int i = CFG_LENGTH_LIMIT + 1; i < 8; i++) begin
      write_register(cfg_idx_t'(i), byte_t'($urandom));
    end
    send_frame(8'h09, 8'h0A, 8'd5, pl, FAULT_NONE, STUFF_RANDOM);

    // random phases, each with its own registers and idling
    for (int p = 0; p < 4; p++) begin
      wait_for_results();
      case (p)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          apply_setting(RST_HEADER_FIRST, RST_HEADER_SECOND, RST_TAIL_FIRST, RST_TAIL_SECOND,
                        byte_t'(RST_LENGTH_LIMIT));
        end
        1: begin
          send_idle_pct = 55; recv_stall_pct = 0;
          apply_setting(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                        byte_t'($urandom), byte_t'($urandom_range(1, PAYLOAD_MAX)));
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 55;
          apply_setting(8'h00, 8'hFF, 8'hFF, 8'h00, 8'd12);
        end
        default: begin
          send_idle_pct = 15; recv_stall_pct = 15;
          apply_setting(ESC_BYTE, 8'h00, 8'h00, 8'hFF, 8'd15);
        end
      endcase
      phase_start = sent_count;
      paused      = 1'b0;
      while (sent_count - phase_start < RANDOM_BYTES_PER_PHASE) begin
        // one pause per phase until every result is out
        if (!paused && sent_count - phase_start >= RANDOM_BYTES_PER_PHASE / 2) begin
          wait_for_results();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        len  = $urandom_range(0, sb.effective_limit());
        pl   = random_payload();
        if (pick < 65) fault = FAULT_NONE;
        else if (pick < 88) fault = frame_fault_e'($urandom_range(FAULT_HEADER, FAULT_TAIL2));
        else begin
          // line noise, then back to hunting
          repeat ($urandom_range(1, 8)) send_byte(byte_t'($urandom));
          send_flush();
          continue;
        end
        if (fault == FAULT_LENGTH) len = $urandom_range(sb.effective_limit() + 1, 255);
        if (fault == FAULT_ESCAPE && len == 0) fault = FAULT_CRC;
        send_frame(byte_t'($urandom), byte_t'($urandom), byte_t'(len), pl, fault,
                   STUFF_RANDOM);
      end
    end

    wait_for_results();
    if (sb.error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
